// File: src/rtt_pkg.sv
// Shared types and constants for the windowed RTT statistics block.
// No dependencies.
package rtt_pkg;
    localparam int WINDOW_DEPTH_DEF = 64;
    localparam logic [15:0] INTERVAL_RESET = 16'd1000;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1500;
    localparam logic CFG_INTERVAL = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;
    localparam logic KIND_REPORT = 1'b0;
    localparam logic [47:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
    // x / 10 == (x * TEN_RECIP) >> TEN_SHIFT for every x below 2^22.
    localparam logic [19:0] TEN_RECIP = 20'd838861;
    localparam int TEN_SHIFT = 23;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture item, push report
        logic check;     // interval compare
        logic drop;      // test front entry age, pop if stale
        logic rd;        // issue RAM read of next entry
        logic acc;       // accumulate returned entry
        logic div_start;
        logic div_step;
        logic ewma_mul;  // form 7*old + 3*mean
        logic ewma_scale; // multiply by the reciprocal of ten
        logic finish;    // commit results
        logic empty_fin; // commit empty window result
        logic show;      // output registers valid
    } rtt_cmd_t;

    typedef struct packed {
        logic due;
        logic stale;
        logic empty;
        logic last_rd;
        logic div_done;
    } rtt_sts_t;
endpackage

// File: src/rtt_window_max_avg_ewma_top.sv
// Windowed RTT maximum, mean and exponential average, top level.
// An evaluating item is answered once stale reports are dropped, every stored entry is
// scanned and the bit-serial mean division (DW = 24 at depth 64) is done; an empty window
// skips scan and division, and no evaluation due skips all three. One item in flight,
// set by the single RAM read port and the bit-serial mean divider.
// Reset (aresetn low, synchronous) empties the window and restores the held values.
module rtt_window_max_avg_ewma_top #(
    parameter int WINDOW_DEPTH = rtt_pkg::WINDOW_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic [15:0]        s_rtt_ms,
    input  logic [31:0]        s_now_ms,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_evaluated,
    output logic signed [16:0] m_max_rtt,
    output logic signed [16:0] m_smoothed_rtt,
    output logic [47:0]        m_avg_sum,
    output logic [31:0]        m_avg_count,
    output logic signed [32:0] m_first_report_time
);
    rtt_pkg::rtt_cmd_t cmd;
    rtt_pkg::rtt_sts_t sts;

    // Configuration transfers are always taken; the user must send them only while idle (unchecked).
    assign cfg_ready = 1'b1;

    // The controller sequences each item: push, interval check, stale drop,
    // window scan, mean division, EWMA by reciprocal multiplication and commit.
    // The next input transfer can follow in the cycle after the result transfer.
    rtt_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .sts(sts), .cmd(cmd));

    rtt_dp #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_kind(s_kind), .s_rtt_ms(s_rtt_ms), .s_now_ms(s_now_ms),
        .m_evaluated(m_evaluated), .m_max_rtt(m_max_rtt),
        .m_smoothed_rtt(m_smoothed_rtt), .m_avg_sum(m_avg_sum),
        .m_avg_count(m_avg_count), .m_first_report_time(m_first_report_time));
endmodule

// File: src/rtt_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module rtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: src/rtt_ctrl.sv
// Controller state machine for the RTT statistics block.
// Depends on rtt_pkg.
module rtt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  rtt_pkg::rtt_sts_t sts,
    output rtt_pkg::rtt_cmd_t cmd
);
    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_CHECK = 11'b00000000010,
        ST_FRONT = 11'b00000000100,
        ST_DROP  = 11'b00000001000,
        ST_SCAN  = 11'b00000010000,
        ST_DIV   = 11'b00000100000,
        ST_MUL   = 11'b00001000000,
        ST_EDIV  = 11'b00010000000,
        ST_FIN   = 11'b00100000000,
        ST_EMPTY = 11'b01000000000,
        ST_OUT   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic   pend_reg, pend_next;   // one read still in flight during scan

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pend_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg <= pend_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        pend_next = 1'b0;
        cmd = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.check = 1'b1;
                state_next = sts.due ? ST_FRONT : ST_OUT;
            end
            ST_FRONT: begin
                // The read address already points at the front entry, so its
                // time is returned in the next cycle.
                if (sts.empty) begin
                    state_next = ST_EMPTY;
                end else begin
                    state_next = ST_DROP;
                end
            end
            ST_DROP: begin
                cmd.drop = 1'b1;
                if (sts.stale) begin
                    state_next = ST_FRONT;
                end else begin
                    cmd.rd = 1'b1;
                    pend_next = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (pend_reg) begin
                    cmd.acc = 1'b1;
                end
                if (!sts.last_rd) begin
                    cmd.rd = 1'b1;
                    pend_next = 1'b1;
                end else if (!pend_reg) begin
                    cmd.div_start = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_done) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.ewma_mul = 1'b1;
                state_next = ST_EDIV;
            end
            ST_EDIV: begin
                cmd.ewma_scale = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_EMPTY: begin
                cmd.empty_fin = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                cmd.show = 1'b1;
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

// File: src/rtt_dp.sv
// Datapath: window ring store, scan accumulators, restoring divider for the mean,
// EWMA by reciprocal multiplication and held statistics. Depends on rtt_pkg and rtt_ram.
module rtt_dp #(
    parameter int WINDOW_DEPTH = rtt_pkg::WINDOW_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  rtt_pkg::rtt_cmd_t cmd,
    output rtt_pkg::rtt_sts_t sts,
    input  logic              cfg_valid,
    input  logic              cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic              s_kind,
    input  logic [15:0]       s_rtt_ms,
    input  logic [31:0]       s_now_ms,
    output logic              m_evaluated,
    output logic signed [16:0] m_max_rtt,
    output logic signed [16:0] m_smoothed_rtt,
    output logic [47:0]       m_avg_sum,
    output logic [31:0]       m_avg_count,
    output logic signed [32:0] m_first_report_time
);
    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int FW = $clog2(WINDOW_DEPTH + 1);
    localparam int SW = 16 + FW;           // window sum width
    localparam int DW = (SW > 24) ? SW : 24; // divider dividend width
    localparam int CW = $clog2(DW + 1);
    localparam logic [FW-1:0] FULL = FW'(WINDOW_DEPTH);

    logic [15:0] interval_reg, timeout_reg;
    logic [AW-1:0] head_reg, rd_idx_reg, waddr;
    logic [FW-1:0] fill_reg, rd_cnt_reg;
    logic [32:0] last_eval_reg;   // value + 1, 0 means "minus one"
    logic signed [16:0] max_reg, ewma_reg;
    logic [47:0] sum_reg;
    logic [31:0] count_reg;
    logic signed [32:0] first_reg;
    logic evaluated_reg;
    logic [31:0] now_reg;
    logic [15:0] scan_max_reg;
    logic [SW-1:0] scan_sum_reg;
    logic [DW-1:0] quo_reg, rem_reg;
    logic [23:0] dvs_reg;
    logic [CW-1:0] div_cnt_reg;
    logic [15:0] rd_rtt;
    logic [31:0] rd_time;
    logic we;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] i);
        logic [AW:0] s;
        s = {1'b0, i} + 1'b1;
        wrap_inc = (s >= (AW+1)'(WINDOW_DEPTH)) ? '0 : s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                               input logic [FW-1:0] b);
        logic [FW:0] s;
        s = (FW+1)'(a) + (FW+1)'(b);
        wrap_add = (s >= (FW+1)'(WINDOW_DEPTH)) ?
            AW'(s - (FW+1)'(WINDOW_DEPTH)) : AW'(s);
    endfunction

    // Push on load: a full window first drops its oldest entry.
    logic [AW-1:0] push_head;
    logic [FW-1:0] push_fill;
    always_comb begin
        push_head = (fill_reg >= FULL) ? wrap_inc(head_reg) : head_reg;
        push_fill = (fill_reg >= FULL) ? FW'(WINDOW_DEPTH - 1) : fill_reg;
        waddr = wrap_add(push_head, push_fill);
        we = cmd.load && (s_kind == rtt_pkg::KIND_REPORT);
    end

    rtt_ram #(.WIDTH(16), .DEPTH(WINDOW_DEPTH)) u_rtt_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(s_rtt_ms),
        .raddr(rd_idx_reg), .rdata(rd_rtt));
    rtt_ram #(.WIDTH(32), .DEPTH(WINDOW_DEPTH)) u_time_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(s_now_ms),
        .raddr(rd_idx_reg), .rdata(rd_time));

    logic [33:0] due_lhs, due_rhs;
    logic [32:0] age;
    always_comb begin
        due_lhs = {2'b00, now_reg} + 34'd1;
        due_rhs = {1'b0, last_eval_reg} + {18'd0, interval_reg};
        age = {1'b0, now_reg} - {1'b0, rd_time};
        sts.due = due_lhs >= due_rhs;
        sts.empty = (fill_reg == '0);
        sts.stale = !age[32] && (age[31:0] > {16'd0, timeout_reg});
        sts.last_rd = (rd_cnt_reg == fill_reg);
        sts.div_done = (div_cnt_reg == '0);
    end

    // One quotient bit per step of the restoring divider.
    logic [DW:0] trial;
    logic [DW-1:0] rem_sh;
    always_comb begin
        rem_sh = {rem_reg[DW-2:0], quo_reg[DW-1]};
        trial = {1'b0, rem_sh} - {{(DW-23){1'b0}}, dvs_reg};
    end

    logic [19:0] ewma_q;
    logic [39:0] ewma_prod;
    logic [48:0] sum_add;
    always_comb begin
        ewma_q = 20'(quo_reg);
        ewma_prod = 40'(quo_reg[19:0]) * 40'(rtt_pkg::TEN_RECIP);
        sum_add = {1'b0, sum_reg} + {33'd0, ewma_q[15:0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= rtt_pkg::INTERVAL_RESET;
            timeout_reg <= rtt_pkg::TIMEOUT_RESET;
            head_reg <= '0;
            fill_reg <= '0;
            last_eval_reg <= '0;
            max_reg <= -17'sd1;
            ewma_reg <= -17'sd1;
            sum_reg <= '0;
            count_reg <= '0;
            first_reg <= -33'sd1;
            evaluated_reg <= 1'b0;
            div_cnt_reg <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    rtt_pkg::CFG_INTERVAL: interval_reg <= cfg_data;
                    rtt_pkg::CFG_TIMEOUT: timeout_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.load) begin
                now_reg <= s_now_ms;
                evaluated_reg <= 1'b0;
                if (s_kind == rtt_pkg::KIND_REPORT) begin
                    head_reg <= push_head;
                    fill_reg <= push_fill + 1'b1;
                    if (first_reg < 0) begin
                        first_reg <= $signed({1'b0, s_now_ms});
                    end
                end
            end
            if (cmd.check) begin
                rd_idx_reg <= head_reg;
                if (sts.due) begin
                    last_eval_reg <= {1'b0, now_reg} + 33'd1;
                    evaluated_reg <= 1'b1;
                end
            end
            if (cmd.drop) begin
                if (sts.stale) begin
                    head_reg <= wrap_inc(head_reg);
                    fill_reg <= fill_reg - 1'b1;
                    rd_idx_reg <= wrap_inc(head_reg);
                end else begin
                    rd_idx_reg <= wrap_inc(head_reg);
                    rd_cnt_reg <= FW'(1);
                    scan_max_reg <= '0;
                    scan_sum_reg <= '0;
                end
            end else if (cmd.rd) begin
                rd_idx_reg <= wrap_inc(rd_idx_reg);
                rd_cnt_reg <= rd_cnt_reg + 1'b1;
            end
            if (cmd.acc) begin
                if (rd_rtt > scan_max_reg) begin
                    scan_max_reg <= rd_rtt;
                end
                scan_sum_reg <= scan_sum_reg + SW'(rd_rtt);
            end
            if (cmd.div_start) begin
                quo_reg <= DW'(scan_sum_reg);
                rem_reg <= '0;
                dvs_reg <= 24'(fill_reg);
                div_cnt_reg <= CW'(DW);
            end else if (cmd.ewma_mul) begin
                // 7*old + 3*mean fits in 20 bits; a restart scales the mean by ten.
                quo_reg <= (ewma_reg < 0) ? DW'(20'(quo_reg) * 20'd10) :
                    DW'(20'(ewma_reg[15:0]) * 20'd7 + 20'(quo_reg[15:0]) * 20'd3);
            end else if (cmd.ewma_scale) begin
                quo_reg <= DW'(ewma_prod[39:rtt_pkg::TEN_SHIFT]);
            end else if (cmd.div_step && div_cnt_reg != '0) begin
                div_cnt_reg <= div_cnt_reg - 1'b1;
                if (!trial[DW]) begin
                    rem_reg <= trial[DW-1:0];
                    quo_reg <= {quo_reg[DW-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[DW-2:0], 1'b0};
                end
            end
            if (cmd.finish) begin
                max_reg <= $signed({1'b0, scan_max_reg});
                ewma_reg <= $signed({1'b0, ewma_q[15:0]});
                sum_reg <= sum_add[48] ? rtt_pkg::SUM_MAX : sum_add[47:0];
                if (count_reg != rtt_pkg::COUNT_MAX) begin
                    count_reg <= count_reg + 32'd1;
                end
            end
            if (cmd.empty_fin) begin
                max_reg <= -17'sd1;
                ewma_reg <= -17'sd1;
            end
        end
    end

    assign m_evaluated = evaluated_reg;
    assign m_max_rtt = max_reg;
    assign m_smoothed_rtt = ewma_reg;
    assign m_avg_sum = sum_reg;
    assign m_avg_count = count_reg;
    assign m_first_report_time = first_reg;
endmodule

// File: src/rtt_checker.sv
// Port-level checks for the RTT statistics block, bound to the top level.
// Depends on rtt_window_max_avg_ewma_top.
module rtt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_evaluated,
    input logic [31:0] m_avg_count,
    input logic signed [16:0] m_max_rtt
);
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken while result pending");
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready) else $error("second input taken");
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_avg_count))
        else $error("result dropped");
    a_count_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> m_avg_count >= $past(m_avg_count))
        else $error("count went down");
    a_empty_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_evaluated && $past(!aresetn) |-> m_max_rtt == -17'sd1)
        else $error("max not reset");
endmodule

bind rtt_window_max_avg_ewma_top rtt_checker u_rtt_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_evaluated(m_evaluated),
    .m_avg_count(m_avg_count), .m_max_rtt(m_max_rtt));

// File: test/rtt_window_max_avg_ewma_top_tb.sv
// Testbench for the windowed RTT maximum, mean and exponential average block.
// Predicts each result in a behavioral model of the window and compares it field by field.
// Depends on rtt_pkg and rtt_window_max_avg_ewma_top.
module rtt_window_max_avg_ewma_top_tb;
    localparam int DEPTH = 64;
    localparam int IDLE_LIMIT = 20000;
    localparam int EXP_DEPTH = 8;

    // Clock, reset and all block inputs start at known values.
    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_index = rtt_pkg::CFG_INTERVAL;
    logic [15:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_kind = rtt_pkg::KIND_REPORT;
    logic [15:0]        s_rtt_ms = '0;
    logic [31:0]        s_now_ms = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_evaluated;
    logic signed [16:0] m_max_rtt;
    logic signed [16:0] m_smoothed_rtt;
    logic [47:0]        m_avg_sum;
    logic [31:0]        m_avg_count;
    logic signed [32:0] m_first_report_time;

    always #4 aclk = ~aclk;

    rtt_window_max_avg_ewma_top dut (.*);

    // One expected result transfer.
    typedef struct packed {
        logic               evaluated;
        logic signed [16:0] max_rtt;
        logic signed [16:0] smoothed_rtt;
        logic [47:0]        avg_sum;
        logic [31:0]        avg_count;
        logic signed [32:0] first_report_time;
    } rtt_stats_t;

    // Expected results in order; written at input transfers, read at result transfers.
    rtt_stats_t exp_fifo[EXP_DEPTH];
    int         exp_wr = 0;
    int         exp_rd = 0;

    // Prediction state, a mirror of what the block holds.
    logic [15:0]        win_rtt[DEPTH];
    logic [31:0]        win_time[DEPTH];
    int                 win_head;
    int                 win_fill;
    longint             last_eval;
    logic signed [16:0] max_held;
    logic signed [16:0] ewma_held;
    logic [47:0]        sum_held;
    logic [31:0]        count_held;
    logic signed [32:0] first_held;
    logic [15:0]        interval_ms;
    logic [15:0]        timeout_ms;

    bit     failed = 1'b0;
    bit     quiet = 1'b0;     // no idling on either side near the end
    int     idle_cycles = 0;
    logic [31:0] clock_ms = '0; // running time base for the stimulus

    // Computes the result of one item and updates the mirrored window state.
    function automatic rtt_stats_t predict_stats(logic kind, logic [15:0] rtt, logic [31:0] now);
        rtt_stats_t r;
        longint     total;
        int         peak;
        int         idx;
        longint     mean;
        longint     sum_next;
        r.evaluated = 1'b0;
        if (kind == rtt_pkg::KIND_REPORT) begin
            // A full window loses its oldest report before the new one goes in.
            if (win_fill >= DEPTH) begin
                win_head = (win_head + 1) % DEPTH;
                win_fill = DEPTH - 1;
            end
            idx = (win_head + win_fill) % DEPTH;
            win_rtt[idx] = rtt;
            win_time[idx] = now;
            win_fill++;
            if (first_held < 0)
                first_held = {1'b0, now};
        end
        if (longint'(now) >= last_eval + longint'(interval_ms)) begin
            r.evaluated = 1'b1;
            last_eval = now;
            // Stale reports leave from the front; a report from the future is never stale.
            while (win_fill > 0 &&
                   longint'(now) - longint'(win_time[win_head]) > longint'(timeout_ms)) begin
                win_head = (win_head + 1) % DEPTH;
                win_fill--;
            end
            if (win_fill == 0) begin
                max_held = -1;
                ewma_held = -1;
            end else begin
                total = 0;
                peak = 0;
                for (int i = 0; i < win_fill; i++) begin
                    idx = (win_head + i) % DEPTH;
                    total += win_rtt[idx];
                    if (win_rtt[idx] > peak)
                        peak = win_rtt[idx];
                end
                mean = total / win_fill;
                max_held = peak;
                // Weight 3/10 in exact integer arithmetic, truncated.
                if (ewma_held < 0)
                    ewma_held = mean;
                else
                    ewma_held = (longint'(ewma_held) * 7 + mean * 3) / 10;
                sum_next = longint'(sum_held) + longint'(ewma_held);
                sum_held = (sum_next > longint'(rtt_pkg::SUM_MAX)) ?
                    rtt_pkg::SUM_MAX : sum_next[47:0];
                if (count_held != rtt_pkg::COUNT_MAX)
                    count_held++;
            end
        end
        r.max_rtt = max_held;
        r.smoothed_rtt = ewma_held;
        r.avg_sum = sum_held;
        r.avg_count = count_held;
        r.first_report_time = first_held;
        return r;
    endfunction

    // Sends one item; the expectation is queued when the transfer happens.
    // Valid drops at the start of an idle gap, or before a drain.
    task automatic send_item(logic kind, logic [15:0] rtt, logic [31:0] now);
        int gap;
        if (!quiet && $urandom_range(3) == 0) begin
            gap = $urandom_range(1, 11);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_rtt_ms <= rtt;
        s_now_ms <= now;
        do @(posedge aclk); while (!s_ready);
        exp_fifo[exp_wr % EXP_DEPTH] = predict_stats(kind, rtt, now);
        exp_wr++;
        @(negedge aclk);
    endtask

    // Writes a register while the block is idle; the caller drops valid afterwards.
    task automatic write_reg(logic index, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (index == rtt_pkg::CFG_INTERVAL)
            interval_ms = value;
        else
            timeout_ms = value;
        @(negedge aclk);
    endtask

    // Waits until every expected result has arrived, then past the longest evaluation.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (exp_wr != exp_rd)
            @(negedge aclk);
        repeat (200) @(negedge aclk);
    endtask

    task automatic reconfigure(logic [15:0] interval, logic [15:0] timeout);
        drain_results();
        write_reg(rtt_pkg::CFG_INTERVAL, interval);
        write_reg(rtt_pkg::CFG_TIMEOUT, timeout);
        cfg_valid <= 1'b0;
    endtask

    // Reset defaults: first evaluation edge, future report, full store, time jumps.
    task automatic test_directed();
        send_item(1'b1, 16'hFFFF, 32'd0);        // tick with nothing stored
        send_item(rtt_pkg::KIND_REPORT, 16'h0000, 32'd5);
        send_item(rtt_pkg::KIND_REPORT, 16'hFFFF, 32'd998);
        send_item(rtt_pkg::KIND_REPORT, 16'd100, 32'd999); // first evaluation edge
        send_item(1'b1, 16'd0, 32'd1998);
        send_item(rtt_pkg::KIND_REPORT, 16'd7, 32'd1999);
        send_item(1'b1, 16'd0, 32'd2999);
        send_item(1'b1, 16'd0, 32'd9000);         // everything stale, window empty
        send_item(rtt_pkg::KIND_REPORT, 16'd40, 32'd12000); // average restarts from the mean
        send_item(rtt_pkg::KIND_REPORT, 16'hAAAA, 32'd11000); // time going backwards
        send_item(1'b1, 16'd0, 32'd13000);
        // Overfill the store without evaluating.
        for (int i = 0; i < DEPTH + 4; i++)
            send_item(rtt_pkg::KIND_REPORT, 16'(i * 997), 32'd13100);
        send_item(1'b1, 16'd0, 32'd14000);
        send_item(1'b1, 16'd0, 32'hFFFF_FFFF);
        send_item(rtt_pkg::KIND_REPORT, 16'h5555, 32'hFFFF_FFFF);
    endtask

    // Zero interval and zero timeout: every item evaluates unless time goes back, older reports drop.
    task automatic test_zero_settings();
        reconfigure(16'd0, 16'd0);
        send_item(rtt_pkg::KIND_REPORT, 16'd10, 32'hFFFF_FFFF);
        send_item(1'b1, 16'd0, 32'hFFFF_FFFF);
        send_item(rtt_pkg::KIND_REPORT, 16'd20, 32'hFFFF_FFFF);
        send_item(rtt_pkg::KIND_REPORT, 16'hFFFF, 32'h8000_0000);
    endtask

    // Random reports and ticks under a given setting; time mostly moves forward.
    task automatic test_random(int count, logic [15:0] interval, logic [15:0] timeout);
        logic        kind;
        logic [15:0] rtt;
        logic [31:0] now;
        int          step;
        reconfigure(interval, timeout);
        clock_ms = $urandom_range(0, 2000);
        for (int i = 0; i < count; i++) begin
            kind = ($urandom_range(3) == 0);
            case ($urandom_range(9))
                0: rtt = 16'hFFFF;
                1: rtt = $urandom();
                default: rtt = $urandom_range(0, 600);
            endcase
            case ($urandom_range(19))
                0: step = 0;
                1: step = 3 * int'(interval) + 2 * int'(timeout);
                default: step = $urandom_range(0, int'(interval) / 4 + 2);
            endcase
            clock_ms = clock_ms + step;
            now = clock_ms;
            if ($urandom_range(24) == 0)
                now = clock_ms - $urandom_range(0, 50);   // occasional step backwards
            send_item(kind, rtt, now);
        end
    endtask

    // Large times exercise the upper bits of the time input and the due and age arithmetic.
    task automatic test_high_times();
        reconfigure(16'hFFFF, 16'hFFFF);
        for (int i = 0; i < 40; i++)
            send_item(i % 5 == 4, $urandom(), 32'hFFF0_0000 + i * 16'hFFF0);
    endtask

    // Result side: random stalls, field by field comparison with the oldest expectation.
    always @(posedge aclk) begin
        rtt_stats_t want;
        rtt_stats_t got;
        if (m_valid && m_ready) begin
            got = '{m_evaluated, m_max_rtt, m_smoothed_rtt, m_avg_sum, m_avg_count,
                    m_first_report_time};
            if (exp_wr == exp_rd) begin
                $display("%0t: unexpected result transfer %p", $time, got);
                failed = 1'b1;
            end else begin
                want = exp_fifo[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (got.evaluated !== want.evaluated) begin
                    $display("%0t: evaluated exp %0d got %0d", $time, want.evaluated, got.evaluated);
                    failed = 1'b1;
                end
                if (got.max_rtt !== want.max_rtt) begin
                    $display("%0t: max_rtt exp %0d got %0d", $time, want.max_rtt, got.max_rtt);
                    failed = 1'b1;
                end
                if (got.smoothed_rtt !== want.smoothed_rtt) begin
                    $display("%0t: smoothed_rtt exp %0d got %0d", $time, want.smoothed_rtt,
                             got.smoothed_rtt);
                    failed = 1'b1;
                end
                if (got.avg_sum !== want.avg_sum) begin
                    $display("%0t: avg_sum exp %0d got %0d", $time, want.avg_sum, got.avg_sum);
                    failed = 1'b1;
                end
                if (got.avg_count !== want.avg_count) begin
                    $display("%0t: avg_count exp %0d got %0d", $time, want.avg_count,
                             got.avg_count);
                    failed = 1'b1;
                end
                if (got.first_report_time !== want.first_report_time) begin
                    $display("%0t: first_report_time exp %0d got %0d", $time,
                             want.first_report_time, got.first_report_time);
                    failed = 1'b1;
                end
            end
        end
    end

    // The receiver stalls in bursts of random length, decided at the falling edge.
    initial begin
        int stall;
        forever begin
            @(negedge aclk);
            if (!quiet && $urandom_range(3) == 0) begin
                stall = $urandom_range(1, 11);
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // The watchdog ends a run in which no transfer happens for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("rtt_window_max_avg_ewma_top_tb failed");
            $finish;
        end
    end

    initial begin
        win_head = 0;
        win_fill = 0;
        last_eval = -1;
        max_held = -1;
        ewma_held = -1;
        sum_held = '0;
        count_held = '0;
        first_held = -1;
        interval_ms = rtt_pkg::INTERVAL_RESET;
        timeout_ms = rtt_pkg::TIMEOUT_RESET;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_zero_settings();
        test_random(150, 16'd1, 16'd65535);
        test_random(150, 16'd200, 16'd700);
        test_random(100, 16'd1000, 16'd1500);
        test_high_times();
        quiet = 1'b1;
        test_random(150, 16'd50, 16'd300);

        drain_results();
        if (!failed)
            $display("rtt_window_max_avg_ewma_top_tb passed");
        else
            $display("rtt_window_max_avg_ewma_top_tb failed");
        $finish;
    end
endmodule
